>>> design/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int CAP_W       = 5;
    localparam int CNT_OUT_W   = 5;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 72;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY      = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_REAR  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_REAR   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,
        OP_SHIFT_UP   = 3'd1,
        OP_SHIFT_DOWN = 3'd2,
        OP_FILL_END   = 3'd3,
        OP_DROP_END   = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [DATA_W-1:0] push_value;
    } cell_ctrl_t;

endpackage

>>> design/cdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_cell
// One slot of the deque chain; shifts with its neighbors or fills/drops at
// the rear end.
// ----------------------------------------------------------------------------
module cdq_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cdq_pkg::cell_ctrl_t          ctrl,
    input  logic                         lower_valid,
    input  logic [cdq_pkg::DATA_W-1:0]   lower_data,
    input  logic                         upper_valid,
    input  logic [cdq_pkg::DATA_W-1:0]   upper_data,
    output logic                         cell_valid,
    output logic [cdq_pkg::DATA_W-1:0]   cell_data,
    output logic                         cell_last
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [cdq_pkg::DATA_W-1:0] data_reg;
    logic [cdq_pkg::DATA_W-1:0] data_next;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (ctrl.op)
            cdq_pkg::OP_SHIFT_UP: begin
                valid_next = lower_valid;
                data_next  = lower_data;
            end
            cdq_pkg::OP_SHIFT_DOWN: begin
                valid_next = upper_valid;
                data_next  = upper_data;
            end
            cdq_pkg::OP_FILL_END: begin
                if (!valid_reg && lower_valid) begin
                    valid_next = 1'b1;
                    data_next  = ctrl.push_value;
                end
            end
            cdq_pkg::OP_DROP_END: begin
                if (valid_reg && !upper_valid) begin
                    valid_next = 1'b0;
                end
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign cell_valid = valid_reg;
    assign cell_data  = data_reg;
    assign cell_last  = valid_reg && !upper_valid;

endmodule

>>> design/circular_deque_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_unit
// Bounded double-ended queue of signed 32-bit values built as a shifting
// chain of cells with an explicit entry count.
// ----------------------------------------------------------------------------
//  port group   direction  fields (low bit first)
//  s_*          in         cmd[2:0], push_value[34:3]
//  m_*          out        succeeded, front_value, rear_value, is_empty,
//                          is_full, entry_count
//  cfg_*        in         usable_capacity[4:0]
//
//  One transfer per cycle sustained while results are taken. The input
//  transfer updates the cell chain and sets the pending stage; the result
//  register reads the chain and raises m_tvalid as the pending stage moves on.
//  Reset empties all cells, clears the count and sets capacity to 16.
//  A stalled result holds the pending stage; input stalls only when the
//  pending stage is occupied and the result register is full and not taken.
// ----------------------------------------------------------------------------
module circular_deque_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]       cfg_wdata,   // usable_capacity
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cdq_pkg::S_DATA_W-1:0]    s_tdata,     // cmd, push_value, pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cdq_pkg::M_DATA_W-1:0]    m_tdata      // succeeded, front_value,
                                                         // rear_value, is_empty,
                                                         // is_full, entry_count
);

    localparam int N = cdq_pkg::MAX_ENTRIES;
    localparam int W = cdq_pkg::DATA_W;

    logic [cdq_pkg::CAP_W-1:0]    cap_reg;
    logic [cdq_pkg::CNT_W-1:0]    count_reg;
    logic [cdq_pkg::CNT_W-1:0]    count_next;
    logic                         pend_reg;
    logic                         pend_next;
    logic                         ok_reg;
    logic                         ok_next;
    logic                         mvalid_reg;
    logic                         mvalid_next;
    logic [cdq_pkg::M_DATA_W-1:0] mdata_reg;
    logic [cdq_pkg::M_DATA_W-1:0] mdata_next;

    logic                         s_xfer;
    logic                         out_free;
    logic [cdq_pkg::CMD_W-1:0]    cmd;
    logic [W-1:0]                 push_value;
    logic [cdq_pkg::CMP_W-1:0]    cap_ext;
    logic [cdq_pkg::CMP_W-1:0]    cap_eff;
    logic [cdq_pkg::CMP_W-1:0]    count_ext;
    logic                         is_full;
    logic                         is_empty;
    cdq_pkg::cell_ctrl_t          ctrl;

    logic [N-1:0]                 valid_vec;
    logic [N-1:0]                 last_vec;
    logic [W-1:0]                 data_arr [N];
    logic [W-1:0]                 front_value;
    logic [W-1:0]                 rear_value;

    assign cmd        = s_tdata[cdq_pkg::CMD_W-1:0];
    assign push_value = s_tdata[cdq_pkg::CMD_W+W-1:cdq_pkg::CMD_W];

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = !pend_reg || out_free;
    assign s_xfer   = s_tvalid && s_tready;

    assign cap_ext   = cdq_pkg::CMP_W'(cap_reg);
    assign count_ext = cdq_pkg::CMP_W'(count_reg);

    always_comb begin
        cap_eff = cap_ext;
        if (cap_ext == '0) begin
            cap_eff = cdq_pkg::CMP_W'(1);
        end else if (cap_ext > cdq_pkg::CMP_W'(N)) begin
            cap_eff = cdq_pkg::CMP_W'(N);
        end
    end

    assign is_full  = count_ext >= cap_eff;
    assign is_empty = count_reg == '0;

    always_comb begin
        ctrl.op         = cdq_pkg::OP_HOLD;
        ctrl.push_value = push_value;
        count_next      = count_reg;
        ok_next         = ok_reg;
        if (s_xfer) begin
            ok_next = 1'b1;
            unique case (cmd)
                cdq_pkg::CMD_PUSH_FRONT: begin
                    if (is_full) begin
                        ok_next = 1'b0;
                    end else begin
                        ctrl.op    = cdq_pkg::OP_SHIFT_UP;
                        count_next = count_reg + 1'b1;
                    end
                end
                cdq_pkg::CMD_PUSH_REAR: begin
                    if (is_full) begin
                        ok_next = 1'b0;
                    end else begin
                        ctrl.op    = cdq_pkg::OP_FILL_END;
                        count_next = count_reg + 1'b1;
                    end
                end
                cdq_pkg::CMD_POP_FRONT: begin
                    if (is_empty) begin
                        ok_next = 1'b0;
                    end else begin
                        ctrl.op    = cdq_pkg::OP_SHIFT_DOWN;
                        count_next = count_reg - 1'b1;
                    end
                end
                cdq_pkg::CMD_POP_REAR: begin
                    if (is_empty) begin
                        ok_next = 1'b0;
                    end else begin
                        ctrl.op    = cdq_pkg::OP_DROP_END;
                        count_next = count_reg - 1'b1;
                    end
                end
                default: begin
                    ok_next = 1'b1;
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic         lower_valid;
            logic [W-1:0] lower_data;
            logic         upper_valid;
            logic [W-1:0] upper_data;

            if (g == 0) begin : g_first
                assign lower_valid = 1'b1;
                assign lower_data  = push_value;
            end else begin : g_mid_lo
                assign lower_valid = valid_vec[g-1];
                assign lower_data  = data_arr[g-1];
            end

            if (g == N - 1) begin : g_final
                assign upper_valid = 1'b0;
                assign upper_data  = '1;
            end else begin : g_mid_hi
                assign upper_valid = valid_vec[g+1];
                assign upper_data  = data_arr[g+1];
            end

            cdq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .lower_valid (lower_valid),
                .lower_data  (lower_data),
                .upper_valid (upper_valid),
                .upper_data  (upper_data),
                .cell_valid  (valid_vec[g]),
                .cell_data   (data_arr[g]),
                .cell_last   (last_vec[g])
            );
        end
    endgenerate

    always_comb begin
        rear_value = '0;
        for (int i = 0; i < N; i++) begin
            rear_value = rear_value | (data_arr[i] & {W{last_vec[i]}});
        end
        if (is_empty) begin
            rear_value = '1;
        end
    end

    assign front_value = is_empty ? '1 : data_arr[0];

    always_comb begin
        pend_next   = pend_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        if (out_free) begin
            mvalid_next = pend_reg;
            if (pend_reg) begin
                mdata_next = {cdq_pkg::CNT_OUT_W'(count_ext), is_full, is_empty,
                              rear_value, front_value, ok_reg};
            end
            pend_next = 1'b0;
        end
        if (s_xfer) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= cdq_pkg::CAP_RESET;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            mvalid_reg <= mvalid_next;
        end
        ok_reg    <= ok_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_ext <= cdq_pkg::CMP_W'(N))
        else $error("entry count beyond store depth");

    a_count_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("entry count disagrees with occupied cells");

    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, valid_vec} + {{N{1'b0}}, 1'b1}))
        else $error("occupied cells not contiguous from the front");

    a_pend_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg && out_free |=> m_tvalid)
        else $error("pending result not moved to output");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg && !out_free |-> !s_tready)
        else $error("input taken while pending result is blocked");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circular_deque_unit. A short table of directed
// commands covers empty and full deques, both pushes and pops, the unused
// command codes and the capacity edge values; a long randomized stream of
// push/pop/query commands follows under several capacities, including one
// lowered below the current fill level. Every result is compared field by
// field against its table entry or a behavioral deque model in the bench.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HALF_PERIOD  = 6;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [cdq_pkg::CMD_W-1:0] CMD_UNUSED_A = 3'd5;
    localparam logic [cdq_pkg::CMD_W-1:0] CMD_UNUSED_B = 3'd6;
    localparam logic [cdq_pkg::CMD_W-1:0] CMD_UNUSED_C = 3'd7;
    localparam logic [cdq_pkg::DATA_W-1:0] EMPTY_VALUE = '1;

    typedef struct packed {
        logic                             ok;
        logic [cdq_pkg::DATA_W-1:0]       front;
        logic [cdq_pkg::DATA_W-1:0]       rear;
        logic                             empty;
        logic                             full;
        logic [cdq_pkg::CNT_OUT_W-1:0]    count;
    } deque_result_t;

    typedef struct {
        bit                          is_cfg;
        logic [cdq_pkg::CAP_W-1:0]   cap_value;
        logic [cdq_pkg::CMD_W-1:0]   op;
        logic [cdq_pkg::DATA_W-1:0]  value;
        bit                          typed;
        deque_result_t               want;
    } plan_row_t;

    typedef struct {
        int cap;
        int items;
        int push_pct;
        bit idle;
    } phase_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_we;
    logic [cdq_pkg::CAP_W-1:0]       cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [cdq_pkg::S_DATA_W-1:0]    s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [cdq_pkg::M_DATA_W-1:0]    m_tdata;

    logic [cdq_pkg::DATA_W-1:0]      slots [cdq_pkg::MAX_ENTRIES];
    int                              head_slot;
    int                              tail_slot;
    int                              fill_level;
    int                              capacity_reg;

    deque_result_t        awaited_results [$];
    plan_row_t            plan [$];
    int                   mismatch_count;
    int                   quiet_cycles;
    bit                   calm;
    bit                   hold_req;

    circular_deque_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int wrap_up(int i);
        return (i + 1 >= cdq_pkg::MAX_ENTRIES) ? 0 : i + 1;
    endfunction

    function automatic int wrap_down(int i);
        return (i == 0) ? cdq_pkg::MAX_ENTRIES - 1 : i - 1;
    endfunction

    function automatic deque_result_t deque_apply(logic [cdq_pkg::CMD_W-1:0] op,
                                                  logic [cdq_pkg::DATA_W-1:0] value);
        deque_result_t r;
        int            limit;
        bit            full_now;
        bit            empty_now;
        limit = capacity_reg;
        if (limit < 1) limit = 1;
        if (limit > cdq_pkg::MAX_ENTRIES) limit = cdq_pkg::MAX_ENTRIES;
        full_now  = fill_level >= limit;
        empty_now = fill_level == 0;
        r.ok = 1'b1;
        if (op == cdq_pkg::CMD_PUSH_FRONT) begin
            if (full_now) begin
                r.ok = 1'b0;
            end else begin
                head_slot = wrap_down(head_slot);
                slots[head_slot] = value;
                fill_level++;
            end
        end else if (op == cdq_pkg::CMD_PUSH_REAR) begin
            if (full_now) begin
                r.ok = 1'b0;
            end else begin
                slots[tail_slot] = value;
                tail_slot = wrap_up(tail_slot);
                fill_level++;
            end
        end else if (op == cdq_pkg::CMD_POP_FRONT) begin
            if (empty_now) begin
                r.ok = 1'b0;
            end else begin
                head_slot = wrap_up(head_slot);
                fill_level--;
            end
        end else if (op == cdq_pkg::CMD_POP_REAR) begin
            if (empty_now) begin
                r.ok = 1'b0;
            end else begin
                tail_slot = wrap_down(tail_slot);
                fill_level--;
            end
        end
        r.empty = fill_level == 0;
        r.full  = fill_level >= limit;
        r.count = cdq_pkg::CNT_OUT_W'(fill_level);
        r.front = r.empty ? EMPTY_VALUE : slots[head_slot];
        r.rear  = r.empty ? EMPTY_VALUE : slots[wrap_down(tail_slot)];
        return r;
    endfunction

    task automatic add_op(logic [cdq_pkg::CMD_W-1:0] op,
                          logic [cdq_pkg::DATA_W-1:0] value);
        plan_row_t row;
        row = '{default: '0};
        row.op    = op;
        row.value = value;
        plan.push_back(row);
    endtask

    task automatic add_typed(logic [cdq_pkg::CMD_W-1:0] op,
                             logic [cdq_pkg::DATA_W-1:0] value,
                             logic ok, logic [cdq_pkg::DATA_W-1:0] front,
                             logic [cdq_pkg::DATA_W-1:0] rear, logic empty,
                             logic full, int count);
        plan_row_t row;
        row = '{default: '0};
        row.op    = op;
        row.value = value;
        row.typed = 1'b1;
        row.want  = '{ok, front, rear, empty, full, cdq_pkg::CNT_OUT_W'(count)};
        plan.push_back(row);
    endtask

    task automatic add_cfg(logic [cdq_pkg::CAP_W-1:0] v);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg    = 1'b1;
        row.cap_value = v;
        plan.push_back(row);
    endtask

    // Offer one command, hold it until the transfer, then record its result.
    task automatic send_cmd(logic [cdq_pkg::CMD_W-1:0] op,
                            logic [cdq_pkg::DATA_W-1:0] value,
                            bit typed, deque_result_t want);
        deque_result_t r;
        int            gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                s_tdata  <= cdq_pkg::S_DATA_W'({$urandom, $urandom});
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(cdq_pkg::S_DATA_W - cdq_pkg::DATA_W - cdq_pkg::CMD_W){1'b0}},
                     value, op};
        do @(posedge aclk); while (!s_tready);
        r = deque_apply(op, value);
        awaited_results.push_back(typed ? want : r);
    endtask

    task automatic write_capacity(logic [cdq_pkg::CAP_W-1:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        capacity_reg = int'(v);
    endtask

    function automatic logic [cdq_pkg::DATA_W-1:0] pick_value();
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return 32'h7fff_ffff;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [cdq_pkg::CMD_W-1:0] pick_cmd(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            return $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_REAR;
        end
        if (r < 95) begin
            return $urandom_range(0, 1) ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_REAR;
        end
        case ($urandom_range(0, 3))
            0: return cdq_pkg::CMD_QUERY;
            1: return CMD_UNUSED_A;
            2: return CMD_UNUSED_B;
            default: return CMD_UNUSED_C;
        endcase
    endfunction

    function automatic void check_field(string name, logic [cdq_pkg::DATA_W-1:0] want,
                                        logic [cdq_pkg::DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        deque_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_tdata);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("succeeded", cdq_pkg::DATA_W'(want.ok),
                            cdq_pkg::DATA_W'(m_tdata[0]));
                check_field("front_value", want.front, m_tdata[32:1]);
                check_field("rear_value", want.rear, m_tdata[64:33]);
                check_field("is_empty", cdq_pkg::DATA_W'(want.empty),
                            cdq_pkg::DATA_W'(m_tdata[65]));
                check_field("is_full", cdq_pkg::DATA_W'(want.full),
                            cdq_pkg::DATA_W'(m_tdata[66]));
                check_field("entry_count", cdq_pkg::DATA_W'(want.count),
                            cdq_pkg::DATA_W'(m_tdata[71:67]));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** circular_deque_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random back-pressure, plus one long hold on request.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        phase_t                     phases [$];
        deque_result_t              none;
        logic [cdq_pkg::CAP_W-1:0]  cap_pick;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        head_slot      = 0;
        tail_slot      = 0;
        fill_level     = 0;
        capacity_reg   = int'(cdq_pkg::CAP_RESET);
        none           = '0;
        foreach (slots[i]) slots[i] = '0;

        add_typed(cdq_pkg::CMD_QUERY,      '0, 1'b1, '1, '1, 1'b1, 1'b0, 0);
        add_typed(cdq_pkg::CMD_POP_FRONT,  '0, 1'b0, '1, '1, 1'b1, 1'b0, 0);
        add_typed(cdq_pkg::CMD_POP_REAR,   '1, 1'b0, '1, '1, 1'b1, 1'b0, 0);
        add_typed(CMD_UNUSED_C,            '1, 1'b1, '1, '1, 1'b1, 1'b0, 0);
        add_typed(cdq_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff,
                  32'h7fff_ffff, 1'b0, 1'b0, 1);
        add_typed(cdq_pkg::CMD_PUSH_REAR,  32'h8000_0000, 1'b1, 32'h7fff_ffff,
                  32'h8000_0000, 1'b0, 1'b0, 2);
        add_op(cdq_pkg::CMD_PUSH_FRONT, '0);
        add_op(cdq_pkg::CMD_PUSH_REAR, '1);
        add_op(CMD_UNUSED_A, 32'h5555_aaaa);
        add_op(CMD_UNUSED_B, 32'haaaa_5555);
        add_op(cdq_pkg::CMD_POP_FRONT, '0);
        add_op(cdq_pkg::CMD_POP_REAR, '0);
        add_op(cdq_pkg::CMD_POP_FRONT, '0);
        add_typed(cdq_pkg::CMD_POP_REAR,   '0, 1'b1, '1, '1, 1'b1, 1'b0, 0);
        add_cfg(cdq_pkg::CAP_W'(1));
        add_typed(cdq_pkg::CMD_PUSH_REAR,  32'h1234_5678, 1'b1, 32'h1234_5678,
                  32'h1234_5678, 1'b0, 1'b1, 1);
        add_typed(cdq_pkg::CMD_PUSH_FRONT, 32'd5, 1'b0, 32'h1234_5678,
                  32'h1234_5678, 1'b0, 1'b1, 1);
        add_typed(cdq_pkg::CMD_POP_FRONT,  '0, 1'b1, '1, '1, 1'b1, 1'b0, 0);
        add_cfg(cdq_pkg::CAP_W'(0));
        add_typed(cdq_pkg::CMD_PUSH_REAR,  32'd9, 1'b1, 32'd9, 32'd9, 1'b0, 1'b1, 1);
        add_typed(cdq_pkg::CMD_PUSH_REAR,  32'd10, 1'b0, 32'd9, 32'd9, 1'b0, 1'b1, 1);
        add_typed(cdq_pkg::CMD_POP_REAR,   '0, 1'b1, '1, '1, 1'b1, 1'b0, 0);

        phases.push_back('{16, 140, 65, 1'b1});
        phases.push_back('{3, 80, 45, 1'b1});
        phases.push_back('{0, 60, 50, 1'b1});
        phases.push_back('{1, 60, 50, 1'b1});
        phases.push_back('{31, 150, 60, 1'b1});
        phases.push_back('{-1, 130, 50, 1'b1});
        phases.push_back('{16, 140, 50, 1'b0});

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_capacity(plan[i].cap_value);
            end else begin
                send_cmd(plan[i].op, plan[i].value, plan[i].typed, plan[i].want);
            end
        end

        foreach (phases[p]) begin
            cap_pick = (phases[p].cap < 0) ? cdq_pkg::CAP_W'($urandom_range(2, 15))
                                            : cdq_pkg::CAP_W'(phases[p].cap);
            write_capacity(cap_pick);
            calm = !phases[p].idle;
            for (int n = 0; n < phases[p].items; n++) begin
                if (p == 0 && n == 30) hold_req = 1'b1;
                send_cmd(pick_cmd(phases[p].push_pct), pick_value(), 1'b0, none);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("** circular_deque_unit: PASSED **");
        end else begin
            $display("** circular_deque_unit: FAILED **");
        end
        $finish;
    end

endmodule
